// File: rtl/core/psdq_pkg.sv
// ----------------------------------------------------------------------------
// psdq_pkg
// Shared constants, datapath op codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package psdq_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = 6;
   localparam int COORD_W      = 16;
   localparam int VCNT_W       = 7;
   localparam int OP_W         = 5;

   // datapath op codes
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_WRITE    = 5'd1;
   localparam logic [OP_W-1:0] OP_START    = 5'd2;
   localparam logic [OP_W-1:0] OP_LOAD_A   = 5'd3;
   localparam logic [OP_W-1:0] OP_LOAD_B   = 5'd4;
   localparam logic [OP_W-1:0] OP_DEN1     = 5'd5;
   localparam logic [OP_W-1:0] OP_DEN2     = 5'd6;
   localparam logic [OP_W-1:0] OP_SIDE1    = 5'd7;
   localparam logic [OP_W-1:0] OP_SIDE2    = 5'd8;
   localparam logic [OP_W-1:0] OP_NUM1     = 5'd9;
   localparam logic [OP_W-1:0] OP_NUM2     = 5'd10;
   localparam logic [OP_W-1:0] OP_CLASS    = 5'd11;
   localparam logic [OP_W-1:0] OP_PX1      = 5'd12;
   localparam logic [OP_W-1:0] OP_PX2      = 5'd13;
   localparam logic [OP_W-1:0] OP_DIVX     = 5'd14;
   localparam logic [OP_W-1:0] OP_CX       = 5'd15;
   localparam logic [OP_W-1:0] OP_PY1      = 5'd16;
   localparam logic [OP_W-1:0] OP_PY2      = 5'd17;
   localparam logic [OP_W-1:0] OP_DIVY     = 5'd18;
   localparam logic [OP_W-1:0] OP_CY       = 5'd19;
   localparam logic [OP_W-1:0] OP_D1       = 5'd20;
   localparam logic [OP_W-1:0] OP_D2       = 5'd21;
   localparam logic [OP_W-1:0] OP_D3       = 5'd22;
   localparam logic [OP_W-1:0] OP_CMP      = 5'd23;
   localparam logic [OP_W-1:0] OP_SQ       = 5'd24;
   localparam logic [OP_W-1:0] OP_DIST     = 5'd25;
   localparam logic [OP_W-1:0] OP_G1       = 5'd26;
   localparam logic [OP_W-1:0] OP_GDIV     = 5'd27;
   localparam logic [OP_W-1:0] OP_GSQ      = 5'd28;
   localparam logic [OP_W-1:0] OP_GSET     = 5'd29;
   localparam logic [OP_W-1:0] OP_OUT      = 5'd30;
   localparam logic [OP_W-1:0] OP_OUT_ZERO = 5'd31;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              rd_en;
      logic [VIDX_W-1:0] rd_addr;
      logic [VIDX_W-1:0] edge_idx;
      logic              comp;      // 0: x component, 1: y component
   } psdq_cmd_type;

   typedef struct packed {
      logic busy;       // divider or root unit running
      logic proj_need;  // interior projection needed on current edge
      logic grad_none;  // zero distance on a degenerate edge
   } psdq_status_type;

endpackage

// File: rtl/core/psdq_ram.sv
// ----------------------------------------------------------------------------
// psdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/psdq_iter.sv
// ----------------------------------------------------------------------------
// psdq_iter
// Shared iterative unit: restoring divider (1 bit/cycle) and rounded
// integer square root (2 bits/cycle).
// ----------------------------------------------------------------------------
module psdq_iter (
   input  logic        clock,
   input  logic        reset,
   input  logic        div_go,
   input  logic        sqrt_go,
   input  logic [63:0] dividend,
   input  logic [34:0] divisor,
   input  logic [35:0] radicand,
   output logic        busy,
   output logic [31:0] quo,
   output logic [17:0] root
);

   localparam logic [6:0] DIV_STEPS  = 7'd64;
   localparam logic [6:0] SQRT_STEPS = 7'd18;

   logic        busy_ff, busy_in;
   logic        mode_ff, mode_in;     // 1: square root
   logic [6:0]  cnt_ff, cnt_in;
   logic [35:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [34:0] dvs_ff, dvs_in;
   logic [35:0] sv_ff, sv_in;
   logic [35:0] sr_ff, sr_in;
   logic [35:0] sb_ff, sb_in;

   logic [35:0] rem_sh;
   logic        ge;
   logic [35:0] st;

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      sv_in   = sv_ff;
      sr_in   = sr_ff;
      sb_in   = sb_ff;
      rem_sh  = {rem_ff[34:0], dvd_ff[63]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      st      = sr_ff + sb_ff;
      if (div_go) begin
         busy_in = 1'b1;
         mode_in = 1'b0;
         cnt_in  = DIV_STEPS;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (sqrt_go) begin
         busy_in = 1'b1;
         mode_in = 1'b1;
         cnt_in  = SQRT_STEPS;
         sv_in   = radicand;
         sr_in   = '0;
         sb_in   = 36'h4_0000_0000;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
         if (!mode_ff) begin
            rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
            dvd_in = {dvd_ff[62:0], ge};
         end else begin
            if (sv_ff >= st) begin
               sv_in = sv_ff - st;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      sv_ff   <= sv_in;
      sr_ff   <= sr_in;
      sb_ff   <= sb_in;
   end

   assign busy = busy_ff;
   assign quo  = dvd_ff[31:0];
   // round to nearest: remainder above root means the upper half
   assign root = sr_ff[17:0] + {17'd0, (sv_ff > sr_ff)};

endmodule

// File: rtl/core/psdq_datapath.sv
// ----------------------------------------------------------------------------
// psdq_datapath
// Vertex store, one shared multiplier, edge/winding/best-edge registers and
// the result register; executes one op per cycle from the controller.
// ----------------------------------------------------------------------------
module psdq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  psdq_pkg::psdq_cmd_type         cmd,
   input  logic [psdq_pkg::VIDX_W-1:0]    req_slot,
   input  logic signed [15:0]             req_x,
   input  logic signed [15:0]             req_y,
   output psdq_pkg::psdq_status_type      status,
   output logic                           polygon_ok,
   output logic                           inside_res,
   output logic signed [17:0]             sdist,
   output logic signed [15:0]             closest_x,
   output logic signed [15:0]             closest_y,
   output logic signed [15:0]             grad_x,
   output logic signed [15:0]             grad_y,
   output logic [psdq_pkg::VIDX_W-1:0]    nearest_edge
);
   import psdq_pkg::*;

   logic [31:0] rd_data;
   logic        busy;
   logic [31:0] quo;
   logic [17:0] root;
   logic        div_go, sqrt_go;
   logic [63:0] dividend;
   logic [34:0] divisor;
   logic [35:0] radicand;

   logic signed [15:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [16:0] ex_ff, ey_ff, rx_ff, ry_ff, dx_ff, dy_ff, c_ff;
   logic signed [51:0] acc_ff;
   logic [33:0]        den_ff, d2_ff;
   logic signed [35:0] side_ff, num_ff;
   logic signed [7:0]  wn_ff;
   logic [33:0]        best_d2_ff, best_den_ff;
   logic [VIDX_W-1:0]  best_edge_ff;
   logic signed [15:0] bcx_ff, bcy_ff, gx_ff, gy_ff;
   logic signed [16:0] bex_ff, bey_ff;
   logic signed [17:0] sd_ff;

   logic               ok_ff, ins_ff;
   logic signed [17:0] osd_ff;
   logic signed [15:0] ocx_ff, ocy_ff, ogx_ff, ogy_ff;
   logic [VIDX_W-1:0]  oedge_ff;

   logic signed [17:0] ma, mb;
   logic signed [35:0] mp;
   logic signed [51:0] mp_ext, sum_add, sum_sub, sum_sh;
   logic signed [16:0] ex_mag, ey_mag, ld_ex, ld_ey, ld_rx, ld_ry, dxs, dys, c_in;
   logic signed [16:0] qs, cxs, cys;
   logic signed [35:0] den_s;
   logic               gmode, in_poly, gneg;
   logic signed [15:0] gval;

   psdq_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vstore (
      .clock   (clock),
      .wr_en   (cmd.op == OP_WRITE),
      .wr_addr (req_slot),
      .wr_data ({req_y, req_x}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   psdq_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .div_go   (div_go),
      .sqrt_go  (sqrt_go),
      .dividend (dividend),
      .divisor  (divisor),
      .radicand (radicand),
      .busy     (busy),
      .quo      (quo),
      .root     (root)
   );

   assign gmode   = (best_d2_ff != 34'd0);
   assign in_poly = (wn_ff != 8'sd0);
   assign den_s   = $signed({2'b00, den_ff});
   assign ex_mag  = ex_ff[16] ? -ex_ff : ex_ff;
   assign ey_mag  = ey_ff[16] ? -ey_ff : ey_ff;
   assign ld_ex   = {rd_data[15], rd_data[15:0]} - {ax_ff[15], ax_ff};
   assign ld_ey   = {rd_data[31], rd_data[31:16]} - {ay_ff[15], ay_ff};
   assign ld_rx   = {px_ff[15], px_ff} - {ax_ff[15], ax_ff};
   assign ld_ry   = {py_ff[15], py_ff} - {ay_ff[15], ay_ff};
   assign dxs     = {px_ff[15], px_ff} - {cx_ff[15], cx_ff};
   assign dys     = {py_ff[15], py_ff} - {cy_ff[15], cy_ff};
   assign qs      = {1'b0, quo[15:0]};
   assign cxs     = {ax_ff[15], ax_ff} + (ex_ff[16] ? -qs : qs);
   assign cys     = {ay_ff[15], ay_ff} + (ey_ff[16] ? -qs : qs);

   always_comb begin
      if (cmd.comp) begin
         c_in = gmode ? ({py_ff[15], py_ff} - {bcy_ff[15], bcy_ff}) : -bex_ff;
      end else begin
         c_in = gmode ? ({px_ff[15], px_ff} - {bcx_ff[15], bcx_ff}) : bey_ff;
      end
   end

   // shared multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_DEN1:  begin ma = {ex_ff[16], ex_ff}; mb = {ex_ff[16], ex_ff}; end
         OP_DEN2:  begin ma = {ey_ff[16], ey_ff}; mb = {ey_ff[16], ey_ff}; end
         OP_SIDE1: begin ma = {ex_ff[16], ex_ff}; mb = {ry_ff[16], ry_ff}; end
         OP_SIDE2: begin ma = {rx_ff[16], rx_ff}; mb = {ey_ff[16], ey_ff}; end
         OP_NUM1:  begin ma = {rx_ff[16], rx_ff}; mb = {ex_ff[16], ex_ff}; end
         OP_NUM2:  begin ma = {ry_ff[16], ry_ff}; mb = {ey_ff[16], ey_ff}; end
         OP_PX1:   begin ma = {1'b0, num_ff[16:0]}; mb = {1'b0, ex_mag}; end
         OP_PX2:   begin ma = {1'b0, num_ff[33:17]}; mb = {1'b0, ex_mag}; end
         OP_PY1:   begin ma = {1'b0, num_ff[16:0]}; mb = {1'b0, ey_mag}; end
         OP_PY2:   begin ma = {1'b0, num_ff[33:17]}; mb = {1'b0, ey_mag}; end
         OP_D2:    begin ma = {dx_ff[16], dx_ff}; mb = {dx_ff[16], dx_ff}; end
         OP_D3:    begin ma = {dy_ff[16], dy_ff}; mb = {dy_ff[16], dy_ff}; end
         OP_G1:    begin ma = {c_in[16], c_in}; mb = {c_in[16], c_in}; end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   assign mp      = ma * mb;
   assign mp_ext  = {{16{mp[35]}}, mp};
   assign sum_add = acc_ff + mp_ext;
   assign sum_sub = acc_ff - mp_ext;
   assign sum_sh  = acc_ff + (mp_ext <<< 17);

   // iterative unit hookup
   always_comb begin
      div_go   = (cmd.op == OP_DIVX) || (cmd.op == OP_DIVY) || (cmd.op == OP_GDIV);
      sqrt_go  = (cmd.op == OP_SQ) || (cmd.op == OP_GSQ);
      dividend = {12'd0, acc_ff[50:0], 1'b0} + {30'd0, den_ff};
      divisor  = {den_ff, 1'b0};
      radicand = {2'b00, best_d2_ff};
      if (cmd.op == OP_GDIV) begin
         dividend = {2'b00, acc_ff[33:0], 28'd0};
         divisor  = gmode ? {1'b0, best_d2_ff} : {1'b0, best_den_ff};
      end
      if (cmd.op == OP_GSQ) begin
         radicand = {4'd0, quo};
      end
   end

   assign gneg = c_ff[16] ^ (gmode & in_poly);
   assign gval = gneg ? -$signed(root[15:0]) : $signed(root[15:0]);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            px_ff      <= req_x;
            py_ff      <= req_y;
            wn_ff      <= 8'sd0;
            best_d2_ff <= '1;
            gx_ff      <= '0;
            gy_ff      <= '0;
         end
         OP_LOAD_A: begin
            ax_ff <= rd_data[15:0];
            ay_ff <= rd_data[31:16];
         end
         OP_LOAD_B: begin
            bx_ff <= rd_data[15:0];
            by_ff <= rd_data[31:16];
            ex_ff <= ld_ex;
            ey_ff <= ld_ey;
            rx_ff <= ld_rx;
            ry_ff <= ld_ry;
         end
         OP_DEN1, OP_SIDE1, OP_NUM1, OP_PX1, OP_PY1, OP_D2, OP_G1: begin
            acc_ff <= mp_ext;
            if (cmd.op == OP_G1) begin
               c_ff <= c_in;
            end
         end
         OP_DEN2:  den_ff  <= sum_add[33:0];
         OP_SIDE2: side_ff <= sum_sub[35:0];
         OP_NUM2:  num_ff  <= sum_add[35:0];
         OP_CLASS: begin
            // crossing rule for the winding number
            if (ay_ff <= py_ff) begin
               if ((by_ff > py_ff) && (side_ff > 36'sd0)) begin
                  wn_ff <= wn_ff + 8'sd1;
               end
            end else if ((by_ff <= py_ff) && (side_ff < 36'sd0)) begin
               wn_ff <= wn_ff - 8'sd1;
            end
            if ((den_ff != 34'd0) && (num_ff >= den_s)) begin
               cx_ff <= bx_ff;
               cy_ff <= by_ff;
            end else begin
               cx_ff <= ax_ff;
               cy_ff <= ay_ff;
            end
         end
         OP_PX2, OP_PY2: acc_ff <= sum_sh;
         OP_CX: cx_ff <= cxs[15:0];
         OP_CY: cy_ff <= cys[15:0];
         OP_D1: begin
            dx_ff <= dxs;
            dy_ff <= dys;
         end
         OP_D3: d2_ff <= sum_add[33:0];
         OP_CMP: begin
            // strict compare keeps the first edge on a tie
            if (d2_ff < best_d2_ff) begin
               best_d2_ff   <= d2_ff;
               best_edge_ff <= cmd.edge_idx;
               bcx_ff       <= cx_ff;
               bcy_ff       <= cy_ff;
               bex_ff       <= ex_ff;
               bey_ff       <= ey_ff;
               best_den_ff  <= den_ff;
            end
            ax_ff <= bx_ff;
            ay_ff <= by_ff;
         end
         OP_DIST: sd_ff <= in_poly ? -$signed(root) : $signed(root);
         OP_GSET: begin
            if (cmd.comp) begin
               gy_ff <= gval;
            end else begin
               gx_ff <= gval;
            end
         end
         OP_OUT: begin
            ok_ff    <= 1'b1;
            ins_ff   <= in_poly;
            osd_ff   <= sd_ff;
            ocx_ff   <= bcx_ff;
            ocy_ff   <= bcy_ff;
            ogx_ff   <= gx_ff;
            ogy_ff   <= gy_ff;
            oedge_ff <= best_edge_ff;
         end
         OP_OUT_ZERO: begin
            ok_ff    <= 1'b0;
            ins_ff   <= 1'b0;
            osd_ff   <= '0;
            ocx_ff   <= '0;
            ocy_ff   <= '0;
            ogx_ff   <= '0;
            ogy_ff   <= '0;
            oedge_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   assign status.busy      = busy;
   assign status.proj_need = (den_ff != 34'd0) && (num_ff > 36'sd0) && (num_ff < den_s);
   assign status.grad_none = (best_d2_ff == 34'd0) && (best_den_ff == 34'd0);

   assign polygon_ok   = ok_ff;
   assign inside_res   = ins_ff;
   assign sdist        = osd_ff;
   assign closest_x    = ocx_ff;
   assign closest_y    = ocy_ff;
   assign grad_x       = ogx_ff;
   assign grad_y       = ogy_ff;
   assign nearest_edge = oedge_ff;

endmodule

// File: rtl/core/psdq_ctrl.sv
// ----------------------------------------------------------------------------
// psdq_ctrl
// Sequencer: request intake, per-edge op sequence, final distance and
// gradient steps, vertex count register and result valid.
// ----------------------------------------------------------------------------
module psdq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_kind,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_valid,
   input  logic [psdq_pkg::VCNT_W-1:0]     csr_data,
   output logic                            csr_ready,
   input  psdq_pkg::psdq_status_type       status,
   output psdq_pkg::psdq_cmd_type          cmd
);
   import psdq_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_ZERO  = 5'd1;
   localparam logic [4:0] ST_RD0W  = 5'd2;
   localparam logic [4:0] ST_EDGEW = 5'd3;
   localparam logic [4:0] ST_DEN1  = 5'd4;
   localparam logic [4:0] ST_DEN2  = 5'd5;
   localparam logic [4:0] ST_SIDE1 = 5'd6;
   localparam logic [4:0] ST_SIDE2 = 5'd7;
   localparam logic [4:0] ST_NUM1  = 5'd8;
   localparam logic [4:0] ST_NUM2  = 5'd9;
   localparam logic [4:0] ST_CLASS = 5'd10;
   localparam logic [4:0] ST_PX1   = 5'd11;
   localparam logic [4:0] ST_PX2   = 5'd12;
   localparam logic [4:0] ST_DIVX  = 5'd13;
   localparam logic [4:0] ST_WDX   = 5'd14;
   localparam logic [4:0] ST_PY1   = 5'd15;
   localparam logic [4:0] ST_PY2   = 5'd16;
   localparam logic [4:0] ST_DIVY  = 5'd17;
   localparam logic [4:0] ST_WDY   = 5'd18;
   localparam logic [4:0] ST_D1    = 5'd19;
   localparam logic [4:0] ST_D2    = 5'd20;
   localparam logic [4:0] ST_D3    = 5'd21;
   localparam logic [4:0] ST_CMP   = 5'd22;
   localparam logic [4:0] ST_FSQ   = 5'd23;
   localparam logic [4:0] ST_WSQ   = 5'd24;
   localparam logic [4:0] ST_G1    = 5'd25;
   localparam logic [4:0] ST_GDIV  = 5'd26;
   localparam logic [4:0] ST_WGD   = 5'd27;
   localparam logic [4:0] ST_WGS   = 5'd28;
   localparam logic [4:0] ST_OUT   = 5'd29;

   localparam logic [VCNT_W-1:0] MAX_N = VCNT_W'(MAX_VERTICES);

   logic [4:0]        state_ff, state_in;
   logic [VIDX_W-1:0] i_ff, i_in;
   logic              comp_ff, comp_in;
   logic [VCNT_W-1:0] vcnt_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [VCNT_W-1:0] n_use, i_p1, i_p2;
   logic              out_free, out_fire;

   assign n_use    = (vcnt_ff > MAX_N) ? MAX_N : vcnt_ff;
   assign i_p1     = {1'b0, i_ff} + 7'd1;
   assign i_p2     = {1'b0, i_ff} + 7'd2;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      comp_in      = comp_ff;
      cmd.op       = OP_NONE;
      cmd.rd_en    = 1'b0;
      cmd.rd_addr  = '0;
      cmd.edge_idx = i_ff;
      cmd.comp     = comp_ff;
      out_fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == REQ_LOAD) begin
                  cmd.op = OP_WRITE;
               end else if (n_use < 7'd3) begin
                  state_in = ST_ZERO;
               end else begin
                  cmd.op      = OP_START;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = '0;
                  i_in        = '0;
                  state_in    = ST_RD0W;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               cmd.op   = OP_OUT_ZERO;
               out_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD0W: begin
            cmd.op      = OP_LOAD_A;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = VIDX_W'(1);
            state_in    = ST_EDGEW;
         end
         ST_EDGEW: begin cmd.op = OP_LOAD_B; state_in = ST_DEN1;  end
         ST_DEN1:  begin cmd.op = OP_DEN1;   state_in = ST_DEN2;  end
         ST_DEN2:  begin cmd.op = OP_DEN2;   state_in = ST_SIDE1; end
         ST_SIDE1: begin cmd.op = OP_SIDE1;  state_in = ST_SIDE2; end
         ST_SIDE2: begin cmd.op = OP_SIDE2;  state_in = ST_NUM1;  end
         ST_NUM1:  begin cmd.op = OP_NUM1;   state_in = ST_NUM2;  end
         ST_NUM2:  begin cmd.op = OP_NUM2;   state_in = ST_CLASS; end
         ST_CLASS: begin
            cmd.op   = OP_CLASS;
            state_in = status.proj_need ? ST_PX1 : ST_D1;
         end
         ST_PX1:  begin cmd.op = OP_PX1;  state_in = ST_PX2;  end
         ST_PX2:  begin cmd.op = OP_PX2;  state_in = ST_DIVX; end
         ST_DIVX: begin cmd.op = OP_DIVX; state_in = ST_WDX;  end
         ST_WDX: begin
            if (!status.busy) begin
               cmd.op   = OP_CX;
               state_in = ST_PY1;
            end
         end
         ST_PY1:  begin cmd.op = OP_PY1;  state_in = ST_PY2;  end
         ST_PY2:  begin cmd.op = OP_PY2;  state_in = ST_DIVY; end
         ST_DIVY: begin cmd.op = OP_DIVY; state_in = ST_WDY;  end
         ST_WDY: begin
            if (!status.busy) begin
               cmd.op   = OP_CY;
               state_in = ST_D1;
            end
         end
         ST_D1: begin cmd.op = OP_D1; state_in = ST_D2; end
         ST_D2: begin cmd.op = OP_D2; state_in = ST_D3; end
         ST_D3: begin cmd.op = OP_D3; state_in = ST_CMP; end
         ST_CMP: begin
            cmd.op = OP_CMP;
            if (i_p1 == n_use) begin
               state_in = ST_FSQ;
            end else begin
               // fetch far vertex of the next edge, wrapping to vertex 0
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = (i_p2 == n_use) ? '0 : i_p2[VIDX_W-1:0];
               i_in        = i_p1[VIDX_W-1:0];
               state_in    = ST_EDGEW;
            end
         end
         ST_FSQ: begin cmd.op = OP_SQ; state_in = ST_WSQ; end
         ST_WSQ: begin
            if (!status.busy) begin
               cmd.op   = OP_DIST;
               comp_in  = 1'b0;
               state_in = status.grad_none ? ST_OUT : ST_G1;
            end
         end
         ST_G1:   begin cmd.op = OP_G1;   state_in = ST_GDIV; end
         ST_GDIV: begin cmd.op = OP_GDIV; state_in = ST_WGD;  end
         ST_WGD: begin
            if (!status.busy) begin
               cmd.op   = OP_GSQ;
               state_in = ST_WGS;
            end
         end
         ST_WGS: begin
            if (!status.busy) begin
               cmd.op = OP_GSET;
               if (comp_ff) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in  = 1'b1;
                  state_in = ST_G1;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op   = OP_OUT;
               out_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         comp_ff      <= 1'b0;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            vcnt_ff <= csr_data;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// File: rtl/core/polygon_signed_distance_query_top.sv
// ----------------------------------------------------------------------------
// polygon_signed_distance_query_top
// Signed distance, closest boundary point and unit gradient of a query point
// against a stored closed polygon.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_* writes vertex_count (polygon size, saturated to 64). Write only
//    while no request is in flight.
//  - req_* carries a load (tuser 0: store the vertex in its slot) or a
//    query (tuser 1). A load gives no response.
//  - rsp_* returns one result per query, held until rsp_tready.
//  - Query steps: with fewer than three vertices a zeroed result is sent;
//    else the per-edge op sequence runs for each edge, plus two products,
//    a divide and one update per axis for each edge whose nearest point lies
//    inside the segment, then the distance root and the gradient (two
//    divides and two roots), with setup and output steps around them.
//    The shared bit-serial divider dominates the query time.
//  - One request at a time; req_tready returns high when the sequencer is
//    idle, even while the previous result still waits on a stalled receiver.
//  - A finished query holds its result internally until the output register
//    frees up.
//  - Reset clears the vertex count and all control; vertex slots hold
//    nothing defined until loaded.
// ----------------------------------------------------------------------------
module polygon_signed_distance_query_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // vertex_slot[5:0], coord_x[21:6], coord_y[37:22]
   input  logic [0:0]  req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // polygon_ok[0], inside_res[1],
                                    // sdist[19:2], closest_x[35:20],
                                    // closest_y[51:36], grad_x[67:52],
                                    // grad_y[83:68], nearest_edge[89:84]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // vertex_count
);
   import psdq_pkg::*;

   psdq_cmd_type    cmd;
   psdq_status_type status;

   logic               polygon_ok, inside_res;
   logic signed [17:0] sdist;
   logic signed [15:0] closest_x, closest_y, grad_x, grad_y;
   logic [VIDX_W-1:0]  nearest_edge;

   // sequencer
   psdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser[0]),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // vertex store, arithmetic and result register
   psdq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_slot     (req_tdata[5:0]),
      .req_x        (req_tdata[21:6]),
      .req_y        (req_tdata[37:22]),
      .status       (status),
      .polygon_ok   (polygon_ok),
      .inside_res   (inside_res),
      .sdist        (sdist),
      .closest_x    (closest_x),
      .closest_y    (closest_y),
      .grad_x       (grad_x),
      .grad_y       (grad_y),
      .nearest_edge (nearest_edge)
   );

   assign rsp_tdata = {6'd0, nearest_edge, grad_y, grad_x, closest_y, closest_x,
                       sdist, inside_res, polygon_ok};

endmodule
